/* rtl/core/fat_directory_block_manager_defines.svh */
// Assertion macros for the FAT directory block manager checker.
// No dependencies; included by the checker file only.
`ifndef FAT_DIRECTORY_BLOCK_MANAGER_DEFINES_SVH
`define FAT_DIRECTORY_BLOCK_MANAGER_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define FDBM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion, also checked during reset
`define FDBM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/fdbm_pkg.sv */
// Shared types and codes for the FAT directory block manager.
// No dependencies; used by controller, datapath, top level and checker.
package fdbm_pkg;

  localparam logic [2:0] FN_CREATE = 3'd0;
  localparam logic [2:0] FN_REMOVE = 3'd1;
  localparam logic [2:0] FN_FIRST  = 3'd2;
  localparam logic [2:0] FN_APPEND = 3'd3;
  localparam logic [2:0] FN_DELETE = 3'd4;
  localparam logic [2:0] FN_CHECK  = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EXISTS    = 3'd1;
  localparam logic [2:0] ST_ROOT_FULL = 3'd2;
  localparam logic [2:0] ST_NO_FILE   = 3'd3;
  localparam logic [2:0] ST_NOT_EMPTY = 3'd4;
  localparam logic [2:0] ST_NOT_OWNED = 3'd5;
  localparam logic [2:0] ST_DISK_FULL = 3'd6;

  typedef enum logic [1:0] {RD_HEAD, RD_CUR, RD_BN} rd_sel_t;
  typedef enum logic [2:0] {WA_CLR, WA_ALLOC, WA_CUR, WA_PREV, WA_BN} wa_sel_t;
  typedef enum logic [2:0] {WD_INIT, WD_ZERO, WD_ALLOC, WD_LINK, WD_HEAD} wd_sel_t;
  typedef enum logic [1:0] {BLK_ZERO, BLK_FB, BLK_ALLOC, BLK_LINK} blk_sel_t;

  typedef struct packed {
    logic       clr_step;
    logic       latch;
    logic       scan_rd;
    logic       scan_cmp;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_en;
    wa_sel_t    wa_sel;
    wd_sel_t    wd_sel;
    logic       cur_fb;
    logic       cur_link;
    logic       cnt_clr;
    logic       prev_cur;
    logic       alloc_take;
    logic       head_link;
    logic       head_bn;
    logic       dir_create;
    logic       dir_remove;
    logic       fb_alloc;
    logic       fb_link;
    logic       done;
    logic [2:0] status;
    blk_sel_t   blk_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       match;
    logic       scan_last;
    logic       hit;
    logic       free_found;
    logic       fb_zero;
    logic       fb_eq_bn;
    logic       bn_ok;
    logic       bn_zero;
    logic       head_ok;
    logic       link_zero;
    logic       link_eq_bn;
    logic       cnt_max;
    logic [2:0] func;
  } dp_sts_t;

endpackage

/* rtl/core/fat_directory_block_manager.sv */
// Top level of the FAT directory block manager.
// Depends on fdbm_pkg, fdbm_ctrl and fdbm_datapath.
//
// A command is taken when start is high and busy is low; its single result
// (status, block number) shows on out_status / out_block_out for exactly one
// cycle with out_valid high, the cycle busy falls, and must be captured then.
// One command at a time: the directory scan reads and compares one root entry
// after another up to the matching one (all ROOT_ENTRIES on a miss or a
// successful create), then dispatch, any chain walk one link at a time
// through the single-port link table, and the update follow. After reset,
// busy stays high while the link table is swept to its free-chain state.
module fat_directory_block_manager #(
  parameter int NUM_BLOCKS   = 256,
  parameter int ROOT_ENTRIES = 16,
  parameter int BLOCK_SIZE   = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [47:0] in_file_name,
  input  logic [7:0]  in_block_num,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_block_out
);
  import fdbm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  fdbm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  fdbm_datapath #(
    .NUM_BLOCKS   (NUM_BLOCKS),
    .ROOT_ENTRIES (ROOT_ENTRIES),
    .BLOCK_SIZE   (BLOCK_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_file_name  (in_file_name),
    .in_block_num  (in_block_num),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_block_out (out_block_out)
  );

endmodule

/* rtl/core/fdbm_datapath.sv */
// Datapath: directory memories, valid bits, link table memory, free head, walk registers.
// Depends on fdbm_pkg; driven by fdbm_ctrl.
module fdbm_datapath #(
  parameter int NUM_BLOCKS   = 256,
  parameter int ROOT_ENTRIES = 16,
  parameter int BLOCK_SIZE   = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [2:0]       in_func,
  input  logic [47:0]      in_file_name,
  input  logic [7:0]       in_block_num,
  input  fdbm_pkg::dp_cmd_t cmd,
  output fdbm_pkg::dp_sts_t sts,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [7:0]       out_block_out
);
  import fdbm_pkg::*;

  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int IW = $clog2(ROOT_ENTRIES);
  localparam int FIRST_FREE = (NUM_BLOCKS * 6) / BLOCK_SIZE + 3;

  logic [47:0]   name_mem [ROOT_ENTRIES];
  logic [BW-1:0] fb_mem   [ROOT_ENTRIES];
  logic [BW-1:0] link_mem [NUM_BLOCKS];
  logic [ROOT_ENTRIES-1:0] valid_r;

  logic [2:0]    func_r;
  logic [47:0]   name_r;
  logic [7:0]    bn_r;
  logic [IW-1:0] idx_r, hit_idx_r, free_idx_r;
  logic          hit_r, free_found_r;
  logic [47:0]   name_rd_r;
  logic [BW-1:0] fb_rd_r, fb_r, cur_r, prev_r, alloc_r, head_r, link_rd_r, clr_r, cnt_r;
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [7:0]    out_blk_r;

  logic [BW-1:0] bn_b, init_val, ra, wa, wd, blk_val;
  logic          match;

  assign bn_b  = BW'(bn_r);
  assign match = valid_r[idx_r] && (name_rd_r == name_r);
  assign init_val = ((32'(clr_r) >= FIRST_FREE) && (32'(clr_r) + 1 < NUM_BLOCKS)) ?
                    clr_r + 1'b1 : '0;

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD: ra = head_r;
      RD_CUR:  ra = cur_r;
      RD_BN:   ra = bn_b;
      default: ra = cur_r;
    endcase
    case (cmd.wa_sel)
      WA_CLR:   wa = clr_r;
      WA_ALLOC: wa = alloc_r;
      WA_CUR:   wa = cur_r;
      WA_PREV:  wa = prev_r;
      WA_BN:    wa = bn_b;
      default:  wa = cur_r;
    endcase
    case (cmd.wd_sel)
      WD_INIT:  wd = init_val;
      WD_ZERO:  wd = '0;
      WD_ALLOC: wd = alloc_r;
      WD_LINK:  wd = link_rd_r;
      WD_HEAD:  wd = head_r;
      default:  wd = '0;
    endcase
    case (cmd.blk_sel)
      BLK_ZERO:  blk_val = '0;
      BLK_FB:    blk_val = fb_r;
      BLK_ALLOC: blk_val = alloc_r;
      BLK_LINK:  blk_val = link_rd_r;
      default:   blk_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      link_mem[wa] <= wd;
    end
    if (cmd.rd_en) begin
      link_rd_r <= link_mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dir_create) begin
      name_mem[free_idx_r] <= name_r;
      fb_mem[free_idx_r]   <= '0;
    end else if (cmd.fb_alloc) begin
      fb_mem[hit_idx_r] <= alloc_r;
    end else if (cmd.fb_link) begin
      fb_mem[hit_idx_r] <= link_rd_r;
    end
    if (cmd.scan_rd) begin
      name_rd_r <= name_mem[idx_r];
      fb_rd_r   <= fb_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      head_r      <= BW'(FIRST_FREE);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.dir_create) valid_r[free_idx_r] <= 1'b1;
      if (cmd.dir_remove) valid_r[hit_idx_r] <= 1'b0;
      if (cmd.head_link) head_r <= link_rd_r;
      else if (cmd.head_bn) head_r <= bn_b;
      out_valid_r <= cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r       <= in_func;
      name_r       <= in_file_name;
      bn_r         <= in_block_num;
      idx_r        <= '0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan_cmp) begin
      idx_r <= idx_r + 1'b1;
      if (match) begin
        hit_r     <= 1'b1;
        hit_idx_r <= idx_r;
        fb_r      <= fb_rd_r;
      end
      if (!valid_r[idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_r;
      end
    end
    if (cmd.cur_fb) cur_r <= fb_r;
    else if (cmd.cur_link) cur_r <= link_rd_r;
    if (cmd.cnt_clr) cnt_r <= '0;
    else if (cmd.cur_link) cnt_r <= cnt_r + 1'b1;
    if (cmd.prev_cur) prev_r <= cur_r;
    if (cmd.alloc_take) alloc_r <= head_r;
    if (cmd.done) begin
      out_status_r <= cmd.status;
      out_blk_r    <= 8'(blk_val);
    end
  end

  always_comb begin
    sts.clr_last   = (clr_r == BW'(NUM_BLOCKS - 1));
    sts.match      = match;
    sts.scan_last  = (idx_r == IW'(ROOT_ENTRIES - 1));
    sts.hit        = hit_r;
    sts.free_found = free_found_r;
    sts.fb_zero    = (fb_r == '0);
    sts.fb_eq_bn   = (fb_r == bn_b);
    sts.bn_ok      = (32'(bn_r) < NUM_BLOCKS);
    sts.bn_zero    = (bn_r == 8'd0);
    sts.head_ok    = (head_r != '0) && (32'(head_r) < NUM_BLOCKS);
    sts.link_zero  = (link_rd_r == '0);
    sts.link_eq_bn = (link_rd_r == bn_b);
    sts.cnt_max    = (cnt_r == BW'(NUM_BLOCKS - 1));
    sts.func       = func_r;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_block_out = out_blk_r;

endmodule

/* rtl/core/fdbm_ctrl.sv */
// Controller state machine: init sweep, directory scan, command dispatch, chain walks.
// Depends on fdbm_pkg; drives fdbm_datapath.
module fdbm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  fdbm_pkg::dp_sts_t sts,
  output fdbm_pkg::dp_cmd_t cmd,
  output logic              busy
);
  import fdbm_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SRD, S_SCMP, S_DISP, S_A1, S_AR, S_AW,
    S_WRD, S_WCMP, S_OWNED, S_D2
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        cmd.wr_en    = 1'b1;
        cmd.wa_sel   = WA_CLR;
        cmd.wd_sel   = WD_INIT;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCMP;
      end
      S_SCMP: begin
        cmd.scan_cmp = 1'b1;
        state_nxt    = (sts.match || sts.scan_last) ? S_DISP : S_SRD;
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        cmd.done  = 1'b1;
        cmd.status = ST_OK;
        case (sts.func)
          FN_CREATE: begin
            if (sts.hit) cmd.status = ST_EXISTS;
            else if (!sts.free_found) cmd.status = ST_ROOT_FULL;
            else cmd.dir_create = 1'b1;
          end
          FN_REMOVE: begin
            if (!sts.hit) cmd.status = ST_NO_FILE;
            else if (!sts.fb_zero) cmd.status = ST_NOT_EMPTY;
            else cmd.dir_remove = 1'b1;
          end
          FN_FIRST: begin
            if (!sts.hit) cmd.status = ST_NO_FILE;
            else cmd.blk_sel = BLK_FB;
          end
          FN_APPEND: begin
            if (!sts.hit) cmd.status = ST_NO_FILE;
            else if (!sts.head_ok) cmd.status = ST_DISK_FULL;
            else begin
              cmd.done       = 1'b0;
              cmd.alloc_take = 1'b1;
              cmd.rd_en      = 1'b1;
              cmd.rd_sel     = RD_HEAD;
              state_nxt      = S_A1;
            end
          end
          FN_DELETE, FN_CHECK: begin
            if (!sts.hit) cmd.status = ST_NO_FILE;
            else if (sts.fb_zero || sts.bn_zero || !sts.bn_ok) cmd.status = ST_NOT_OWNED;
            else if (sts.fb_eq_bn) begin
              cmd.done   = 1'b0;
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_BN;
              state_nxt  = S_OWNED;
            end else begin
              cmd.done    = 1'b0;
              cmd.cur_fb  = 1'b1;
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_WRD;
            end
          end
          default: ;
        endcase
      end
      S_A1: begin
        cmd.head_link = 1'b1;
        cmd.wr_en     = 1'b1;
        cmd.wa_sel    = WA_ALLOC;
        cmd.wd_sel    = WD_ZERO;
        if (sts.fb_zero) begin
          cmd.fb_alloc = 1'b1;
          cmd.done     = 1'b1;
          cmd.status   = ST_OK;
          cmd.blk_sel  = BLK_ALLOC;
          state_nxt    = S_IDLE;
        end else begin
          cmd.cur_fb  = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_AR;
        end
      end
      S_AR: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_CUR;
        state_nxt  = S_AW;
      end
      S_AW: begin
        if (sts.link_zero || sts.cnt_max) begin
          cmd.wr_en   = 1'b1;
          cmd.wa_sel  = WA_CUR;
          cmd.wd_sel  = WD_ALLOC;
          cmd.done    = 1'b1;
          cmd.status  = ST_OK;
          cmd.blk_sel = BLK_ALLOC;
          state_nxt   = S_IDLE;
        end else begin
          cmd.cur_link = 1'b1;
          state_nxt    = S_AR;
        end
      end
      S_WRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_CUR;
        state_nxt  = S_WCMP;
      end
      S_WCMP: begin
        if (sts.link_zero || (sts.cnt_max && !sts.link_eq_bn)) begin
          cmd.done   = 1'b1;
          cmd.status = ST_NOT_OWNED;
          state_nxt  = S_IDLE;
        end else if (sts.link_eq_bn) begin
          cmd.prev_cur = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_BN;
          state_nxt    = S_OWNED;
        end else begin
          cmd.cur_link = 1'b1;
          state_nxt    = S_WRD;
        end
      end
      S_OWNED: begin
        if (sts.func == FN_CHECK) begin
          cmd.done    = 1'b1;
          cmd.status  = ST_OK;
          cmd.blk_sel = BLK_LINK;
          state_nxt   = S_IDLE;
        end else begin
          if (sts.fb_eq_bn) cmd.fb_link = 1'b1;
          else begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_PREV;
            cmd.wd_sel = WD_LINK;
          end
          state_nxt = S_D2;
        end
      end
      S_D2: begin
        cmd.wr_en   = 1'b1;
        cmd.wa_sel  = WA_BN;
        cmd.wd_sel  = WD_HEAD;
        cmd.head_bn = 1'b1;
        cmd.done    = 1'b1;
        cmd.status  = ST_OK;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

/* rtl/core/fdbm_checker.sv */
// Port-level checker for the FAT directory block manager, bound to the top level.
// Depends on fdbm_pkg and fat_directory_block_manager_defines.svh.
`include "fat_directory_block_manager_defines.svh"

module fdbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_func,
  input logic [47:0] in_file_name,
  input logic [7:0]  in_block_num,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [7:0]  out_block_out
);
  import fdbm_pkg::*;

  `FDBM_ASSERT_NR(a_reset_quiet, clk, !rst_n |=> !out_valid && busy, "reset must clear strobe and hold busy")
  `FDBM_ASSERT(a_accept_busy, clk, rst_n, start && !busy |=> busy, "accepted transaction must raise busy")
  `FDBM_ASSERT(a_single_strobe, clk, rst_n, out_valid |=> !out_valid, "one result per transaction")
  `FDBM_ASSERT(a_err_block, clk, rst_n, out_valid && out_status != ST_OK |-> out_block_out == 8'd0, "error result must carry block 0")
  `FDBM_ASSERT(a_status_range, clk, rst_n, out_valid |-> out_status != 3'd7, "status code out of range")

endmodule

bind fat_directory_block_manager fdbm_checker u_fdbm_checker (.*);
